FILE: hdl/mbr_pkg.sv
// Package for the Mandelbrot bit-plane renderer.
// Holds the fixed-point format, geometry constants, register indexes and FSM states.
// No dependencies.
package mbr_pkg;

    localparam int FRAC_BITS     = 19;
    localparam int LINE_PIXELS   = 640;
    localparam int WORD_BITS     = 16;
    // power of two: the word address wraps by plain overflow
    localparam int ADDRESS_WORDS = 32768;

    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ITER_W     = 8;
    localparam int COL_W      = $clog2(LINE_PIXELS);
    localparam int BCNT_W     = $clog2(WORD_BITS);
    localparam int ADDR_W     = $clog2(ADDRESS_WORDS);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic signed [COORD_W-1:0] t_fix;

    localparam t_fix MINUS_TWO = t_fix'(-(longint'(2) << FRAC_BITS));
    localparam t_fix FOUR      = t_fix'(longint'(4) << FRAC_BITS);

    localparam t_fix              X_STEP_RST = t_fix'(6554);
    localparam t_fix              Y_STEP_RST = t_fix'(8738);
    localparam logic [ITER_W-1:0] LIMIT_RST  = ITER_W'(100);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = CFG_IDX_W'(2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_XY,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage

FILE: hdl/mandelbrot_bitplane_renderer.sv
// Mandelbrot bit-plane renderer, top level.
// Uses mbr_pkg. One shared 32x32 signed multiplier under a small sequencer.
//
// Usage
//   Input channel (i_in_valid / o_in_stall): one request per pixel. i_frame_start=1
//   restarts the coordinate at (-2.0,-2.0), the bit packer and the word address
//   before that pixel is rendered.
//   Output channel (o_out_valid / i_out_stall): one word per pixel: the escape
//   count, and every 16th pixel a packed word of count bit 0 (first pixel in MSB)
//   with its video memory address; otherwise packed word and address read 0.
//   Config port: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 x_step, 1 y_step, 2 iteration_limit); write only while no pixel is in flight.
// Sequencing
//   Each iteration of z = z*z + c steps through ST_MUL_XY, ST_MUL_XX, ST_MUL_YY and
//   ST_CHECK on the one multiplier (zx*zy, zx*zx, zy*zy, then the escape compare).
//   A pixel runs at most iteration_limit iterations and then loads its result in
//   ST_DONE; the next pixel can be taken the cycle after the result is loaded, and
//   no new pixel is taken before the last one is through.
// Reset and stall
//   Synchronous active-low reset restores default registers, the start
//   coordinate, an empty packer, address 0, and drops o_out_valid.
//   The result sits in an output register; while the receiver stalls, the next
//   pixel is still accepted and computed, and only its final load waits.
module mandelbrot_bitplane_renderer
    import mbr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // pixel input
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_frame_start,
    // result output
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ITER_W-1:0]     o_iterations,
    output logic                  o_word_ready,
    output logic [WORD_BITS-1:0]  o_packed_word,
    output logic [ADDR_W-1:0]     o_word_address,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    // config registers
    t_fix              r_x_step, r_y_step;
    logic [ITER_W-1:0] r_limit;

    // frame position and packer
    t_fix               r_real, r_imag;
    logic [COL_W-1:0]   r_col;
    logic [BCNT_W-1:0]  r_bit_cnt;
    logic [WORD_BITS-1:0] r_shift;
    logic [ADDR_W-1:0]  r_addr;

    // iteration datapath
    t_fix                     r_zx, r_zy, r_sx, r_sy;
    logic signed [PROD_W-1:0] r_prod;
    logic [ITER_W-1:0]        r_iter, r_count;

    // output register
    logic                 r_out_valid;
    logic [ITER_W-1:0]    r_out_iter;
    logic                 r_out_ready;
    logic [WORD_BITS-1:0] r_out_word;
    logic [ADDR_W-1:0]    r_out_addr;

    // shared multiplier
    t_fix                     mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // control and derived values
    logic                 in_accept, load, escape, last;
    logic [ITER_W-1:0]    iter_inc;
    t_fix                 nx, zy_next, sq_now, mag;
    logic [WORD_BITS-1:0] shift_next;
    logic                 word_done;

    always_comb begin
        case (r_state)
            ST_MUL_XY: begin
                mul_a = r_zx;
                mul_b = r_zy;
            end
            ST_MUL_XX: begin
                mul_a = r_zx;
                mul_b = r_zx;
            end
            default: begin
                mul_a = r_zy;
                mul_b = r_zy;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // arithmetic shift of the product, low 32 bits kept
    assign zy_next = t_fix'(r_prod[FRAC_BITS-1 +: COORD_W]) + r_imag;
    assign sq_now  = t_fix'(r_prod[FRAC_BITS +: COORD_W]);
    assign nx      = r_sx - r_sy + r_real;
    assign mag     = r_sx + sq_now;
    assign escape  = mag > FOUR;
    assign iter_inc = r_iter + ITER_W'(1);
    assign last     = (iter_inc == r_limit);

    assign shift_next = {r_shift[WORD_BITS-2:0], r_count[0]};
    assign word_done  = (r_bit_cnt == BCNT_W'(WORD_BITS - 1));

    // next state
    always_comb begin
        n_state   = r_state;
        in_accept = 1'b0;
        load      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                in_accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = (r_limit == '0) ? ST_DONE : ST_MUL_XY;
                end
            end
            ST_MUL_XY: n_state = ST_MUL_XX;
            ST_MUL_XX: n_state = ST_MUL_YY;
            ST_MUL_YY: n_state = ST_CHECK;
            ST_CHECK: begin
                n_state = (escape || last) ? ST_DONE : ST_MUL_XY;
            end
            ST_DONE: begin
                load = !r_out_valid || !i_out_stall;
                if (load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_step <= X_STEP_RST;
            r_y_step <= Y_STEP_RST;
            r_limit  <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_X_STEP:     r_x_step <= t_fix'(i_cfg_data);
                CFG_Y_STEP:     r_y_step <= t_fix'(i_cfg_data);
                CFG_ITER_LIMIT: r_limit  <= i_cfg_data[ITER_W-1:0];
                default: ;
            endcase
        end
    end

    // frame position, packer and address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real    <= MINUS_TWO;
            r_imag    <= MINUS_TWO;
            r_col     <= '0;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_addr    <= '0;
        end else if (in_accept && i_frame_start) begin
            r_real    <= MINUS_TWO;
            r_imag    <= MINUS_TWO;
            r_col     <= '0;
            r_bit_cnt <= '0;
            r_shift   <= '0;
            r_addr    <= '0;
        end else if (load) begin
            if (word_done) begin
                r_bit_cnt <= '0;
                r_shift   <= '0;
                r_addr    <= r_addr + ADDR_W'(1);
            end else begin
                r_bit_cnt <= r_bit_cnt + BCNT_W'(1);
                r_shift   <= shift_next;
            end
            if (r_col == COL_W'(LINE_PIXELS - 1)) begin
                r_col  <= '0;
                r_real <= MINUS_TWO;
                r_imag <= r_imag + r_y_step;
            end else begin
                r_col  <= r_col + COL_W'(1);
                r_real <= r_real + r_x_step;
            end
        end
    end

    // escape-time iteration
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_zx    <= '0;
                r_zy    <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_iter  <= '0;
                r_count <= '0;
            end
            ST_MUL_XY: begin
                r_prod <= mul_p;
                r_zx   <= nx;
            end
            ST_MUL_XX: begin
                r_prod <= mul_p;
                r_zy   <= zy_next;
            end
            ST_MUL_YY: begin
                r_prod <= mul_p;
                r_sx   <= sq_now;
            end
            ST_CHECK: begin
                r_sy <= sq_now;
                if (escape) begin
                    r_count <= r_iter;
                end else if (last) begin
                    r_count <= r_limit;
                end else begin
                    r_iter <= iter_inc;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_iter  <= r_count;
            r_out_ready <= word_done;
            r_out_word  <= word_done ? shift_next : '0;
            r_out_addr  <= word_done ? r_addr : '0;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_iterations   = r_out_iter;
    assign o_word_ready   = r_out_ready;
    assign o_packed_word  = r_out_word;
    assign o_word_address = r_out_addr;

endmodule

FILE: hdl/mbr_checker.sv
// Port-level checks for the Mandelbrot bit-plane renderer.
// Uses mbr_pkg; bound to mandelbrot_bitplane_renderer at the end of this file.
module mbr_checker
    import mbr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_word_ready,
    input logic [WORD_BITS-1:0] o_packed_word,
    input logic [ADDR_W-1:0]    o_word_address
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    // no partial word leaks out
    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_word_ready |-> o_packed_word == '0 && o_word_address == '0)
        else $error("packed word or address nonzero without word_ready");

    // an accepted pixel keeps the input side busy in the cycle after it is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // reset empties the output register
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind mandelbrot_bitplane_renderer mbr_checker u_mbr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_word_ready   (o_word_ready),
    .o_packed_word  (o_packed_word),
    .o_word_address (o_word_address)
);
